// File: sv/bftm_pkg.sv
// Shared sizes, codes and helpers for the tape machine.
`timescale 1ns / 1ps

package bftm_pkg;

  // Storage sizes.
  localparam int unsigned PROG_DEPTH  = 4096;
  localparam int unsigned DATA_DEPTH  = 4096;
  localparam int unsigned STACK_DEPTH = 64;

  // Derived widths.
  localparam int unsigned PA_W = $clog2(PROG_DEPTH);       // program address
  localparam int unsigned IP_W = $clog2(PROG_DEPTH + 1);   // counter, may equal depth
  localparam int unsigned CP_W = $clog2(DATA_DEPTH);       // cell pointer
  localparam int unsigned SA_W = $clog2(STACK_DEPTH);      // stack address
  localparam int unsigned SC_W = $clog2(STACK_DEPTH + 1);  // stack fill count

  // Fixed field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LADDR_W   = 12;
  localparam int unsigned LEN_CFG_W = 13;
  localparam int unsigned PC_W      = 13;
  localparam int unsigned LEN_W     = (IP_W > LEN_CFG_W) ? IP_W : LEN_CFG_W;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_UNMATCHED = 2'd3
  } err_e;

  // Instruction characters.
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

  // Space, tab, line feed, vertical tab, form feed and carriage return.
  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    is_blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

// File: sv/bftm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bftm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bf_tape_machine_step_top.sv
// Top level of the tape machine: sequencer, state registers and the three memories.
`timescale 1ns / 1ps

// Tape machine that runs one instruction per step item. The program, the data
// cells and the loop stack each live in a synchronous RAM with a registered
// read port, and a small sequencer reads, modifies and writes them back. A load
// or no-operation item goes from idle to the done state, and from there its
// result enters the output register as soon as that register can take it. A
// step passes through idle (issue the program, cell and stack-top reads),
// execute, a forward scan if needed, and done (register the result); a step on
// a halted machine goes from idle straight to done. A '[' whose cell is zero
// walks program memory one byte per cycle, from the byte after the '[' up to
// and including its matching ']', or up to the last program byte. After reset,
// and after every restart item, a clearing pass writes zero into each of the
// DATA_DEPTH cells, one per cycle; no item is taken during the pass, while
// configuration writes are. The result of a restart appears when its pass is
// done. One result is produced per item, and the output register lets the
// next item be taken while a result still waits for its transfer. The
// program_length register may only be written while the block is idle; its
// write channel is always ready.
module bf_tape_machine_step_top
  import bftm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LEN_CFG_W-1:0] cfg_data_i,

  // Item input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic [LADDR_W-1:0]   load_address_i,
  input  logic [BYTE_W-1:0]    load_byte_i,
  input  logic [BYTE_W-1:0]    input_byte_i,
  input  logic                 input_valid_i,

  // Result output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    output_byte_o,
  output logic                 output_valid_o,
  output logic                 input_taken_o,
  output logic                 waiting_input_o,
  output logic                 halted_o,
  output logic [1:0]           error_code_o,
  output logic [PC_W-1:0]      program_counter_o
);

  typedef enum logic [2:0] {
    S_CLEAR,  // zero the data cells, one per cycle
    S_IDLE,   // wait for an item; reads for a step are issued here
    S_EXEC,   // execute the fetched instruction
    S_SCAN,   // forward walk to the matching ']'
    S_DONE    // hand the result to the output register
  } state_e;

  state_e               state_q, state_d;
  logic [IP_W-1:0]      ip_q, ip_d;
  logic [CP_W-1:0]      cp_q, cp_d;
  logic [SC_W-1:0]      sc_q, sc_d;
  err_e                 err_q, err_d;
  logic [LEN_CFG_W-1:0] len_q, len_d;
  logic [CP_W-1:0]      clr_q, clr_d;
  logic                 clr_resp_q, clr_resp_d;
  logic [PA_W-1:0]      scan_q, scan_d;
  logic [PA_W-1:0]      depth_q, depth_d;
  logic [BYTE_W-1:0]    step_byte_q, step_byte_d;
  logic                 step_ok_q, step_ok_d;

  // Result of the item in flight.
  logic [BYTE_W-1:0]    res_byte_q, res_byte_d;
  logic                 res_out_q, res_out_d;
  logic                 res_taken_q, res_taken_d;
  logic                 res_wait_q, res_wait_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    obyte_q, obyte_d;
  logic                 oout_q, oout_d;
  logic                 otaken_q, otaken_d;
  logic                 owait_q, owait_d;
  logic                 ohalt_q, ohalt_d;
  logic [1:0]           oerr_q, oerr_d;
  logic [PC_W-1:0]      opc_q, opc_d;

  // Memory ports.
  logic                 prog_we;
  logic [PA_W-1:0]      prog_waddr, prog_raddr;
  logic [BYTE_W-1:0]    prog_wdata, prog_rdata;
  logic                 data_we;
  logic [CP_W-1:0]      data_waddr, data_raddr;
  logic [BYTE_W-1:0]    data_wdata, data_rdata;
  logic                 stack_we;
  logic [SA_W-1:0]      stack_waddr, stack_raddr;
  logic [PA_W-1:0]      stack_wdata, stack_rdata;

  logic [LEN_W-1:0]     act_len;
  logic                 halted_now;
  logic                 advance;
  logic [IP_W-1:0]      ip_next;
  logic [IP_W-1:0]      scan_next;

  // A program length beyond the memory acts as the full memory.
  assign act_len = (LEN_W'(len_q) > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH)
                                                         : LEN_W'(len_q);
  assign halted_now = (err_q != ERR_NONE) || (LEN_W'(ip_q) >= act_len);

  assign ip_next   = ip_q + IP_W'(1);
  assign scan_next = IP_W'(scan_q) + IP_W'(1);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    ip_d        = ip_q;
    cp_d        = cp_q;
    sc_d        = sc_q;
    err_d       = err_q;
    len_d       = len_q;
    clr_d       = clr_q;
    clr_resp_d  = clr_resp_q;
    scan_d      = scan_q;
    depth_d     = depth_q;
    step_byte_d = step_byte_q;
    step_ok_d   = step_ok_q;
    res_byte_d  = res_byte_q;
    res_out_d   = res_out_q;
    res_taken_d = res_taken_q;
    res_wait_d  = res_wait_q;
    out_valid_d = out_valid_q;
    obyte_d     = obyte_q;
    oout_d      = oout_q;
    otaken_d    = otaken_q;
    owait_d     = owait_q;
    ohalt_d     = ohalt_q;
    oerr_d      = oerr_q;
    opc_d       = opc_q;
    advance     = 1'b0;

    // Every read below is issued in the cycle before its data is used. A read
    // issued in the same cycle as a write to the same memory is never used, since
    // the sequencer works on one item at a time.
    prog_we     = 1'b0;
    prog_waddr  = PA_W'(load_address_i);
    prog_wdata  = load_byte_i;
    prog_raddr  = PA_W'(ip_q);
    data_we     = 1'b0;
    data_waddr  = cp_q;
    data_wdata  = data_rdata;
    data_raddr  = cp_q;
    stack_we    = 1'b0;
    stack_waddr = SA_W'(sc_q);
    stack_wdata = PA_W'(ip_q);
    stack_raddr = SA_W'(sc_q - SC_W'(1));  // top of stack; unused when empty

    if (cfg_valid_i) begin
      len_d = cfg_data_i;
    end

    // The waiting result leaves on its transfer.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_q;
        data_wdata = '0;
        clr_d      = clr_q + CP_W'(1);
        if (clr_q == CP_W'(DATA_DEPTH - 1)) begin
          clr_d      = '0;
          clr_resp_d = 1'b0;
          state_d    = clr_resp_q ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_byte_d  = '0;
          res_out_d   = 1'b0;
          res_taken_d = 1'b0;
          res_wait_d  = 1'b0;
          case (op_e'(operation_i))
            OP_LOAD: begin
              // Addresses outside the program memory are dropped.
              prog_we = (32'(load_address_i) < PROG_DEPTH);
              state_d = S_DONE;
            end
            OP_STEP: begin
              step_byte_d = input_byte_i;
              step_ok_d   = input_valid_i;
              state_d     = halted_now ? S_DONE : S_EXEC;
            end
            OP_RESTART: begin
              ip_d       = '0;
              cp_d       = '0;
              sc_d       = '0;
              err_d      = ERR_NONE;
              clr_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        advance = 1'b1;
        case (prog_rdata)
          CH_PLUS: begin
            data_we    = 1'b1;
            data_wdata = data_rdata + BYTE_W'(1);
          end
          CH_MINUS: begin
            data_we    = 1'b1;
            data_wdata = data_rdata - BYTE_W'(1);
          end
          CH_RIGHT: begin
            cp_d = (cp_q == CP_W'(DATA_DEPTH - 1)) ? '0 : cp_q + CP_W'(1);
          end
          CH_LEFT: begin
            cp_d = (cp_q == '0) ? CP_W'(DATA_DEPTH - 1) : cp_q - CP_W'(1);
          end
          CH_DOT: begin
            res_byte_d = data_rdata;
            res_out_d  = 1'b1;
          end
          CH_COMMA: begin
            if (!step_ok_q) begin
              res_wait_d = 1'b1;
              advance    = 1'b0;
            end else begin
              res_taken_d = 1'b1;
              if (is_blank(step_byte_q)) begin
                // Whitespace is swallowed and the instruction keeps waiting.
                res_wait_d = 1'b1;
                advance    = 1'b0;
              end else begin
                data_we    = 1'b1;
                data_wdata = step_byte_q;
              end
            end
          end
          CH_OPEN: begin
            if (data_rdata == '0) begin
              advance = 1'b0;
              if (LEN_W'(ip_next) >= act_len) begin
                err_d = ERR_UNMATCHED;
              end else begin
                prog_raddr = PA_W'(ip_next);
                scan_d     = PA_W'(ip_next);
                depth_d    = '0;
                state_d    = S_SCAN;
              end
            end else if (sc_q >= SC_W'(STACK_DEPTH)) begin
              err_d   = ERR_OVERFLOW;
              advance = 1'b0;
            end else begin
              stack_we = 1'b1;
              sc_d     = sc_q + SC_W'(1);
            end
          end
          CH_CLOSE: begin
            if (sc_q == '0) begin
              err_d   = ERR_UNDERFLOW;
              advance = 1'b0;
            end else if (data_rdata != '0) begin
              // Back to the instruction just after the open bracket.
              ip_d    = IP_W'(stack_rdata) + IP_W'(1);
              advance = 1'b0;
            end else begin
              sc_d = sc_q - SC_W'(1);
            end
          end
          default: begin
          end
        endcase
        if (advance) begin
          ip_d = ip_next;
        end
      end

      S_SCAN: begin
        // prog_rdata holds the byte at scan_q; the next read goes out meanwhile.
        if ((prog_rdata == CH_CLOSE) && (depth_q == '0)) begin
          ip_d    = scan_next;
          state_d = S_DONE;
        end else begin
          case (prog_rdata)
            CH_OPEN:  depth_d = depth_q + PA_W'(1);
            CH_CLOSE: depth_d = depth_q - PA_W'(1);
            default:  depth_d = depth_q;
          endcase
          if (LEN_W'(scan_next) >= act_len) begin
            err_d   = ERR_UNMATCHED;
            state_d = S_DONE;
          end else begin
            prog_raddr = PA_W'(scan_next);
            scan_d     = PA_W'(scan_next);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          obyte_d     = res_byte_q;
          oout_d      = res_out_q;
          otaken_d    = res_taken_q;
          owait_d     = res_wait_q;
          ohalt_d     = halted_now;
          oerr_d      = err_q;
          opc_d       = PC_W'(ip_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ip_q        <= '0;
      cp_q        <= '0;
      sc_q        <= '0;
      err_q       <= ERR_NONE;
      len_q       <= '0;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      scan_q      <= '0;
      depth_q     <= '0;
      step_byte_q <= '0;
      step_ok_q   <= 1'b0;
      res_byte_q  <= '0;
      res_out_q   <= 1'b0;
      res_taken_q <= 1'b0;
      res_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
      obyte_q     <= '0;
      oout_q      <= 1'b0;
      otaken_q    <= 1'b0;
      owait_q     <= 1'b0;
      ohalt_q     <= 1'b0;
      oerr_q      <= '0;
      opc_q       <= '0;
    end else begin
      state_q     <= state_d;
      ip_q        <= ip_d;
      cp_q        <= cp_d;
      sc_q        <= sc_d;
      err_q       <= err_d;
      len_q       <= len_d;
      clr_q       <= clr_d;
      clr_resp_q  <= clr_resp_d;
      scan_q      <= scan_d;
      depth_q     <= depth_d;
      step_byte_q <= step_byte_d;
      step_ok_q   <= step_ok_d;
      res_byte_q  <= res_byte_d;
      res_out_q   <= res_out_d;
      res_taken_q <= res_taken_d;
      res_wait_q  <= res_wait_d;
      out_valid_q <= out_valid_d;
      obyte_q     <= obyte_d;
      oout_q      <= oout_d;
      otaken_q    <= otaken_d;
      owait_q     <= owait_d;
      ohalt_q     <= ohalt_d;
      oerr_q      <= oerr_d;
      opc_q       <= opc_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign output_byte_o     = obyte_q;
  assign output_valid_o    = oout_q;
  assign input_taken_o     = otaken_q;
  assign waiting_input_o   = owait_q;
  assign halted_o          = ohalt_q;
  assign error_code_o      = oerr_q;
  assign program_counter_o = opc_q;

  bftm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  bftm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  bftm_ram #(
    .WIDTH (PA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= SC_W'(STACK_DEPTH))
    else $error("loop stack count beyond its depth");

  a_ip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ip_q <= IP_W'(PROG_DEPTH))
    else $error("program counter beyond program memory");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before the item finished");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((error_code_o == ERR_NONE) || halted_o))
    else $error("error reported without halt");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the tape machine step block.
`timescale 1ns / 1ps

module testbench;
  import bftm_pkg::*;

  // Expected outcome of one item, one field per result port.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_flag;
    logic              taken;
    logic              waiting;
    logic              halt;
    err_e              err;
    logic [PC_W-1:0]   pc;
  } tape_result_t;

  localparam logic [BYTE_W-1:0] INSTR_SET [8] = '{CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT,
                                                  CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE};
  // The blank bytes plus the two neighbors just outside the tab to return range.
  localparam logic [BYTE_W-1:0] BLANK_EDGE [8] = '{8'h08, 8'h09, 8'h0A, 8'h0B,
                                                   8'h0C, 8'h0D, 8'h0E, 8'h20};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [LEN_CFG_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [1:0]           operation = OP_NOP;
  logic [LADDR_W-1:0]   load_address = '0;
  logic [BYTE_W-1:0]    load_byte = '0;
  logic [BYTE_W-1:0]    input_byte = '0;
  logic                 input_valid = 1'b0;
  logic                 out_stall = 1'b0;

  logic                 cfg_ready;
  logic                 in_stall;
  logic                 out_valid;
  logic [BYTE_W-1:0]    output_byte;
  logic                 output_valid;
  logic                 input_taken;
  logic                 waiting_input;
  logic                 halted;
  logic [1:0]           error_code;
  logic [PC_W-1:0]      program_counter;

  // Shadow copy of the machine state used to work out each result.
  logic [BYTE_W-1:0] prog_image [PROG_DEPTH];
  logic [BYTE_W-1:0] cell_image [DATA_DEPTH];
  logic [PA_W-1:0]   loop_image [STACK_DEPTH];
  int unsigned       loop_fill;
  int unsigned       tape_pc;
  int unsigned       tape_ptr;
  int unsigned       run_length = 0;
  err_e              run_error;

  tape_result_t      expected_results [$];
  logic [BYTE_W-1:0] staged_program [$];
  int unsigned       send_gap_pct = 19;
  int unsigned       recv_stall_pct = 73;
  int unsigned       items_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       fault_count = 0;

  bf_tape_machine_step_top u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .load_address_i    (load_address),
    .load_byte_i       (load_byte),
    .input_byte_i      (input_byte),
    .input_valid_i     (input_valid),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .output_byte_o     (output_byte),
    .output_valid_o    (output_valid),
    .input_taken_o     (input_taken),
    .waiting_input_o   (waiting_input),
    .halted_o          (halted),
    .error_code_o      (error_code),
    .program_counter_o (program_counter)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
  endtask

  function automatic int unsigned usable_length();
    return (run_length > PROG_DEPTH) ? PROG_DEPTH : run_length;
  endfunction

  function automatic bit run_stopped();
    return (run_error != ERR_NONE) || (tape_pc >= usable_length());
  endfunction

  task automatic clear_tape();
    foreach (cell_image[k]) cell_image[k] = '0;
    loop_fill = 0;
    tape_pc   = 0;
    tape_ptr  = 0;
    run_error = ERR_NONE;
  endtask

  // Applies one accepted item to the shadow state and queues its result.
  task automatic predict_item(input op_e op, input logic [LADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] lbyte, input logic [BYTE_W-1:0] ibyte,
                              input logic ivalid);
    tape_result_t      r;
    logic [BYTE_W-1:0] instr;
    logic [BYTE_W-1:0] cur_value;
    int unsigned       len;
    int unsigned       close_at;
    int unsigned       depth;
    bit                advance;
    r = '0;
    case (op)
      OP_LOAD: prog_image[addr] = lbyte;
      OP_RESTART: clear_tape();
      OP_STEP: begin
        if (!run_stopped()) begin
          len       = usable_length();
          instr     = prog_image[tape_pc];
          cur_value = cell_image[tape_ptr];
          advance   = 1'b1;
          case (instr)
            CH_PLUS:  cell_image[tape_ptr] = cur_value + 8'd1;
            CH_MINUS: cell_image[tape_ptr] = cur_value - 8'd1;
            CH_RIGHT: tape_ptr = (tape_ptr + 1 >= DATA_DEPTH) ? 0 : tape_ptr + 1;
            CH_LEFT:  tape_ptr = (tape_ptr == 0) ? DATA_DEPTH - 1 : tape_ptr - 1;
            CH_DOT: begin
              r.out_byte = cur_value;
              r.out_flag = 1'b1;
            end
            CH_COMMA: begin
              if (!ivalid) begin
                r.waiting = 1'b1;
                advance   = 1'b0;
              end else begin
                r.taken = 1'b1;
                // Blank bytes are swallowed and the read keeps waiting.
                if (ibyte == 8'h20 || (ibyte >= 8'h09 && ibyte <= 8'h0D)) begin
                  r.waiting = 1'b1;
                  advance   = 1'b0;
                end else begin
                  cell_image[tape_ptr] = ibyte;
                end
              end
            end
            CH_OPEN: begin
              if (cur_value == 8'd0) begin
                close_at = len;
                depth    = 0;
                for (int unsigned i = tape_pc + 1; i < len && close_at == len; i++) begin
                  if (prog_image[i] == CH_OPEN) depth++;
                  else if (prog_image[i] == CH_CLOSE) begin
                    if (depth == 0) close_at = i;
                    else depth--;
                  end
                end
                if (close_at >= len) begin
                  run_error = ERR_UNMATCHED;
                  advance   = 1'b0;
                end else begin
                  tape_pc = close_at;
                end
              end else if (loop_fill >= STACK_DEPTH) begin
                run_error = ERR_OVERFLOW;
                advance   = 1'b0;
              end else begin
                loop_image[loop_fill] = PA_W'(tape_pc);
                loop_fill++;
              end
            end
            CH_CLOSE: begin
              if (loop_fill == 0) begin
                run_error = ERR_UNDERFLOW;
                advance   = 1'b0;
              end else if (cur_value != 8'd0) begin
                tape_pc = loop_image[loop_fill - 1];
              end else begin
                loop_fill--;
              end
            end
            default: ;
          endcase
          if (advance) tape_pc++;
        end
      end
      default: ;
    endcase
    r.halt = run_stopped();
    r.err  = run_error;
    r.pc   = PC_W'(tape_pc);
    expected_results.push_back(r);
  endtask

  // Sends one item; valid stays high after the transfer so that a following
  // item can go out back to back. Whoever pauses the stream lowers it.
  task automatic send_item(input op_e op, input logic [LADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] lbyte, input logic [BYTE_W-1:0] ibyte,
                           input logic ivalid);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    load_address <= addr;
    load_byte    <= lbyte;
    input_byte   <= ibyte;
    input_valid  <= ivalid;
    do @(posedge clk); while (in_stall);
    predict_item(op, addr, lbyte, ibyte, ivalid);
    if (op != OP_NOP) items_sent++;
  endtask

  task automatic step_tape(input logic [BYTE_W-1:0] ibyte, input logic ivalid);
    send_item(OP_STEP, LADDR_W'($urandom_range(4095, 0)), BYTE_W'($urandom_range(255, 0)),
              ibyte, ivalid);
  endtask

  task automatic step_random_input();
    step_tape(($urandom_range(99, 0) < 35) ? BLANK_EDGE[$urandom_range(7, 0)]
                                           : BYTE_W'($urandom_range(255, 0)),
              $urandom_range(99, 0) < 75);
  endtask

  task automatic issue(input op_e op);
    send_item(op, LADDR_W'($urandom_range(4095, 0)), BYTE_W'($urandom_range(255, 0)),
              BYTE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
  endtask

  task automatic load_at(input logic [LADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
    send_item(OP_LOAD, addr, value, BYTE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
  endtask

  // Stops sending, waits for every outstanding result, then a short settle time.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [LEN_CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    run_length = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic stage_text(input string s);
    for (int i = 0; i < s.len(); i++) staged_program.push_back(s[i]);
  endtask

  // Loads the staged bytes from address 0, sets the length and rewinds the run.
  task automatic run_staged(input logic [LEN_CFG_W-1:0] len);
    foreach (staged_program[a]) load_at(LADDR_W'(a), staged_program[a]);
    wait_for_idle();
    cfg_write(len);
    issue(OP_RESTART);
  endtask

  // Results are taken on edges where the stall sampled low; the stall for the
  // next cycle is drawn in the same process so the two never race.
  always @(posedge clk) begin : result_check
    tape_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_fault("result arrived with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (output_byte !== want.out_byte)
          report_fault($sformatf("output_byte %0h, expected %0h", output_byte, want.out_byte));
        if (output_valid !== want.out_flag)
          report_fault($sformatf("output_valid %0b, expected %0b", output_valid, want.out_flag));
        if (input_taken !== want.taken)
          report_fault($sformatf("input_taken %0b, expected %0b", input_taken, want.taken));
        if (waiting_input !== want.waiting)
          report_fault($sformatf("waiting_input %0b, expected %0b", waiting_input, want.waiting));
        if (halted !== want.halt)
          report_fault($sformatf("halted %0b, expected %0b", halted, want.halt));
        if (error_code !== want.err)
          report_fault($sformatf("error_code %0d, expected %0d", error_code, want.err));
        if (program_counter !== want.pc)
          report_fault($sformatf("program_counter %0d, expected %0d", program_counter, want.pc));
      end
    end
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // With a zero length every step reports a halted machine at address 0.
  task automatic test_after_reset();
    step_random_input();
    issue(OP_NOP);
    step_random_input();
    wait_for_idle();
    cfg_write('0);
    step_random_input();
  endtask

  // Every instruction at least once, both pointer wraps, both cell wraps, the read
  // waiting with no byte and with blank bytes, a loop taken twice, a nested
  // forward skip and finally a stack underflow that halts the run.
  task automatic test_instruction_set();
    staged_program.delete();
    stage_text("-<.>+-.,[-]x[[]]]");
    run_staged(LEN_CFG_W'(staged_program.size()));
    for (int s = 0; s < 22; s++) begin
      case (s)
        7:  step_tape(BYTE_W'($urandom_range(255, 0)), 1'b0);
        8:  step_tape(8'h20, 1'b1);
        9:  step_tape(8'h0D, 1'b1);
        10: step_tape(8'h09, 1'b1);
        11: step_tape(8'h02, 1'b1);
        default: step_random_input();
      endcase
    end
    issue(OP_NOP);
    issue(OP_RESTART);
    repeat (3) step_random_input();
  endtask

  // Sixty-five nested opens with a nonzero cell overflow the loop stack; an
  // open with a zero cell and no close anywhere is an unmatched bracket.
  task automatic test_bracket_errors();
    staged_program.delete();
    stage_text("+");
    repeat (STACK_DEPTH + 1) stage_text("[");
    run_staged(LEN_CFG_W'(staged_program.size()));
    repeat (STACK_DEPTH + 3) step_random_input();
    wait_for_idle();
    staged_program.delete();
    stage_text("[+");
    run_staged(LEN_CFG_W'(2));
    repeat (2) step_random_input();
  endtask

  // Fills the whole program memory so that the largest lengths are legal.
  // A skip from the first byte to the last ends the run at the memory size,
  // also with a length above the memory size; without the final close the
  // skip walks to the end and reports an unmatched bracket.
  task automatic test_full_length();
    logic [BYTE_W-1:0] b;
    staged_program.delete();
    staged_program.push_back(CH_OPEN);
    repeat (PROG_DEPTH - 2) begin
      b = BYTE_W'($urandom_range(255, 0));
      if (b == CH_OPEN || b == CH_CLOSE) b = CH_DOT;
      staged_program.push_back(b);
    end
    staged_program.push_back(CH_CLOSE);
    run_staged(LEN_CFG_W'(PROG_DEPTH));
    repeat (2) step_random_input();
    wait_for_idle();
    cfg_write({LEN_CFG_W{1'b1}});
    issue(OP_RESTART);
    step_random_input();
    load_at(LADDR_W'(PROG_DEPTH - 1), CH_PLUS);
    issue(OP_RESTART);
    repeat (2) step_random_input();
    wait_for_idle();
  endtask

  // Random programs, mostly with balanced brackets, run for a random number
  // of steps with loads, restarts and idle items mixed in.
  task automatic test_random_programs(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned budget);
    int unsigned       start;
    int unsigned       size;
    int unsigned       depth;
    int unsigned       r;
    logic [LEN_CFG_W-1:0] len;
    logic [BYTE_W-1:0] b;
    bit                well_formed;
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < budget) begin
      staged_program.delete();
      depth       = 0;
      well_formed = ($urandom_range(99, 0) < 85);
      if ($urandom_range(1, 0)) staged_program.push_back(CH_PLUS);
      repeat ($urandom_range(40, 4)) begin
        r = $urandom_range(99, 0);
        if (!well_formed) begin
          b = (r < 60) ? INSTR_SET[$urandom_range(7, 0)] : BYTE_W'($urandom_range(255, 0));
        end else if (r < 78) begin
          b = INSTR_SET[$urandom_range(5, 0)];
        end else if (r < 88) begin
          b = CH_OPEN;
          depth++;
        end else if (r < 96 && depth > 0) begin
          b = CH_CLOSE;
          depth--;
        end else begin
          b = BYTE_W'($urandom_range(255, 0));
          if (b == CH_OPEN || b == CH_CLOSE) b = 8'h78;
        end
        staged_program.push_back(b);
      end
      while (well_formed && depth > 0) begin
        staged_program.push_back(CH_CLOSE);
        depth--;
      end
      size = staged_program.size();
      // The whole program memory was written earlier, so any length is legal.
      r = $urandom_range(99, 0);
      if (r < 80) len = LEN_CFG_W'(size);
      else if (r < 90) len = LEN_CFG_W'($urandom_range(size, 0));
      else len = LEN_CFG_W'($urandom_range(8191, 0));
      run_staged(len);
      repeat ($urandom_range(3 * size, size)) begin
        r = $urandom_range(99, 0);
        if (r < 5) issue(OP_NOP);
        else if (r < 8) load_at(LADDR_W'($urandom_range(4095, 0)), BYTE_W'($urandom_range(255, 0)));
        else if (r < 9) issue(OP_RESTART);
        else step_random_input();
      end
      wait_for_idle();
    end
  endtask

  initial begin
    int unsigned guard;
    foreach (prog_image[k]) prog_image[k] = '0;
    clear_tape();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_instruction_set();
    test_bracket_errors();
    test_full_length();
    test_random_programs(19, 73, 333);
    test_random_programs(73, 19, 333);
    test_random_programs(0, 0, 334);

    in_valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 500_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0)
      report_fault($sformatf("%0d expected results never arrived", expected_results.size()));

    if (fault_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
